### src/ckpd_pkg.sv
// Shared types and constants for the calibrated knob PWM duty controller.
`default_nettype none
package ckpd_pkg;

    localparam int CKPD_W      = 10;
    localparam int CKPD_PROD_W = 2 * CKPD_W;
    localparam int CKPD_BYTE_W = 8;
    localparam int CKPD_HD_W   = 9;
    localparam int CKPD_SD_W   = 6;
    localparam int CKPD_ADDR_W = 3;
    localparam int CKPD_IDX_W  = 1;
    localparam int CKPD_IN_W   = 24;
    localparam int CKPD_OUT_W  = 40;

    localparam logic [CKPD_W-1:0] CKPD_FULL       = 10'd1023;
    localparam logic [CKPD_W-1:0] CKPD_CURVE_DIV  = 10'd1021;
    localparam logic [CKPD_W-1:0] CKPD_SCALE_DIV  = 10'd1023;
    localparam logic [CKPD_W-1:0] CKPD_HARD_MULT  = 10'd499;
    localparam logic [CKPD_W-1:0] CKPD_SOFT_MULT  = 10'd34;
    localparam logic [CKPD_W-1:0] CKPD_CLAMP_LOW  = 10'd4;
    localparam logic [CKPD_W-1:0] CKPD_CLAMP_HIGH = 10'd1015;
    localparam logic [CKPD_W-1:0] CKPD_CURVE_KNEE = 10'd2;
    localparam logic [CKPD_W-1:0] CKPD_HOLD_MAX   = 10'd1000;
    localparam logic [CKPD_W-1:0] CKPD_HOLD_LONG  = 10'd50;
    localparam logic [CKPD_W-1:0] CKPD_RAMP_TURN  = 10'd1019;
    localparam logic [CKPD_W-1:0] CKPD_RAMP_STEP  = 10'd2;
    localparam logic [CKPD_W:0]   CKPD_RAMP_MARGIN = 11'd4;
    localparam logic [CKPD_BYTE_W-1:0] CKPD_NONE_STORED = 8'hFF;

    localparam logic [CKPD_IDX_W-1:0] CKPD_REG_HARD = 1'b0;
    localparam logic [CKPD_IDX_W-1:0] CKPD_REG_SOFT = 1'b1;

    typedef struct packed {
        logic                   long_hold;
        logic [CKPD_W-1:0]      ramp_level;
        logic [CKPD_W-1:0]      hard_base;
        logic [CKPD_W-1:0]      soft_base;
        logic                   save_strobe;
        logic [CKPD_BYTE_W-1:0] save_hard;
        logic [CKPD_BYTE_W-1:0] save_soft;
    } ckpd_ctrl_t;

    function automatic logic [CKPD_W-1:0] ckpd_decode(input logic [CKPD_BYTE_W-1:0] b);
        return (b == CKPD_NONE_STORED) ? '0 : {b, 2'b00};
    endfunction

endpackage
`default_nettype wire

### src/calibrated_knob_pwm_duty_controller_top.sv
// Top level of the calibrated knob PWM duty controller with stream and register ports.
// Each sample transfer yields exactly one result transfer. The button and ramp state is
// updated at the sample transfer itself. A sample passes through these steps until its
// result is offered: a launch of the two channels, the work in each channel, which runs
// its readings twice through a bit-serial unit (a load step, 10 multiply steps and 20
// divide steps a pass), a capture of both duties and a load of the output register.
// The two channels run side by side, and a new sample is taken from the cycle after the
// result has moved into the output register, so no sample is taken while one is in work,
// and a stalled receiver holds back the next sample. Both calibration registers reset
// to 255 (none stored, offset zero); a write reloads the matching offset at once, and a
// release after a short press overwrites them with the current readings divided by four.
`default_nettype none
module calibrated_knob_pwm_duty_controller_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // button_level [0], hard_sample [10:1], soft_sample [20:11]
    input  wire logic [ckpd_pkg::CKPD_IN_W-1:0]      s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // hw duty [8:0], sw duty [14:9], ramp_active [15], save_strobe [16],
    // save_hard_value [24:17], save_soft_value [32:25]
    output logic [ckpd_pkg::CKPD_OUT_W-1:0]          m_tdata,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [ckpd_pkg::CKPD_ADDR_W-1:0]    paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);
    import ckpd_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_START, ST_RUN, ST_HOLD} top_state_t;

    top_state_t             state_reg;
    logic [CKPD_W-1:0]      hs_reg;
    logic [CKPD_W-1:0]      ss_reg;
    logic                   m_tvalid_reg;
    logic [CKPD_OUT_W-1:0]  m_tdata_reg;
    logic [CKPD_HD_W-1:0]   hd_reg;
    logic [CKPD_SD_W-1:0]   sd_reg;

    logic                   accept;
    logic                   cfg_we;
    logic [CKPD_IDX_W-1:0]  cfg_idx;
    logic                   out_free;
    logic                   lane_start;
    ckpd_ctrl_t             ctrl;
    logic [CKPD_BYTE_W-1:0] shb;
    logic [CKPD_BYTE_W-1:0] ssb;
    logic                   hard_done;
    logic                   soft_done;
    logic [CKPD_HD_W-1:0]   hw_duty_w;
    logic [CKPD_HD_W-1:0]   sw_duty_w;
    logic [CKPD_OUT_W-1:0]  result_word;

    assign s_tready   = state_reg == ST_IDLE;
    assign accept     = s_tvalid && s_tready;
    assign pready     = 1'b1;
    assign cfg_we     = psel && penable && pwrite && pready;
    assign cfg_idx    = paddr[CKPD_ADDR_W-1:2];
    assign out_free   = !m_tvalid_reg || m_tready;
    assign lane_start = state_reg == ST_START;

    always_comb begin
        unique case (cfg_idx)
            CKPD_REG_HARD: prdata = {{(32-CKPD_BYTE_W){1'b0}}, shb};
            CKPD_REG_SOFT: prdata = {{(32-CKPD_BYTE_W){1'b0}}, ssb};
            default:       prdata = '0;
        endcase
    end

    ckpd_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (accept),
        .button          (s_tdata[0]),
        .hard_sample     (s_tdata[10:1]),
        .soft_sample     (s_tdata[20:11]),
        .cfg_we          (cfg_we),
        .cfg_idx         (cfg_idx),
        .cfg_data        (pwdata[CKPD_BYTE_W-1:0]),
        .ctrl            (ctrl),
        .saved_hard_byte (shb),
        .saved_soft_byte (ssb)
    );

    ckpd_lane u_hard_lane (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (lane_start),
        .sample   (hs_reg),
        .offset   (ctrl.hard_base),
        .ovr_en   (ctrl.long_hold),
        .ovr_val  (ctrl.ramp_level),
        .clamp_en (1'b1),
        .mult     (CKPD_HARD_MULT),
        .done     (hard_done),
        .duty     (hw_duty_w)
    );

    ckpd_lane u_soft_lane (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (lane_start),
        .sample   (ss_reg),
        .offset   (ctrl.soft_base),
        .ovr_en   (1'b0),
        .ovr_val  (CKPD_FULL),
        .clamp_en (1'b0),
        .mult     (CKPD_SOFT_MULT),
        .done     (soft_done),
        .duty     (sw_duty_w)
    );

    assign result_word = {7'b0, ctrl.save_soft, ctrl.save_hard, ctrl.save_strobe,
                          ctrl.long_hold, sd_reg, hd_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_HOLD && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        hs_reg    <= s_tdata[10:1];
                        ss_reg    <= s_tdata[20:11];
                        state_reg <= ST_START;
                    end
                end
                ST_START: state_reg <= ST_RUN;
                ST_RUN: begin
                    if (hard_done) begin
                        hd_reg    <= hw_duty_w;
                        sd_reg    <= sw_duty_w[CKPD_SD_W-1:0];
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        m_tdata_reg <= result_word;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_lanes_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        hard_done == soft_done)
        else $error("channel lanes finished in different cycles");

    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready ##1 !s_tready)
        else $error("sample taken while the previous one is still in work");

    a_hard_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[8:0] <= 9'd499)
        else $error("hard duty out of range");

    a_soft_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[14:9] <= 6'd34)
        else $error("soft duty out of range");

    a_strobe_no_ramp: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[16]) |-> !m_tdata[15])
        else $error("save strobe together with active ramp");

endmodule
`default_nettype wire

### src/ckpd_muldiv.sv
// Bit-serial multiply followed by restoring division, one bit per cycle.
`default_nettype none
module ckpd_muldiv (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [ckpd_pkg::CKPD_W-1:0] op_a,
    input  wire logic [ckpd_pkg::CKPD_W-1:0] op_b,
    input  wire logic [ckpd_pkg::CKPD_W-1:0] divisor,
    output logic                           done,
    output logic [ckpd_pkg::CKPD_W-1:0]    quotient
);
    import ckpd_pkg::*;

    localparam int CNT_W = $clog2(CKPD_PROD_W);

    typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV} md_state_t;

    md_state_t               state_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CKPD_W-1:0]       a_reg;
    logic [CKPD_PROD_W-1:0]  b_reg;
    logic [CKPD_PROD_W-1:0]  acc_reg;
    logic [CKPD_PROD_W-1:0]  quot_reg;
    logic [CKPD_W-1:0]       rem_reg;
    logic [CKPD_W-1:0]       div_reg;
    logic                    done_reg;

    logic [CKPD_PROD_W-1:0]  acc_sum;
    logic [CKPD_W:0]         trial;
    logic                    fits;
    logic [CKPD_W:0]         trial_diff;

    assign acc_sum    = acc_reg + (a_reg[0] ? b_reg : '0);
    assign trial      = {rem_reg, quot_reg[CKPD_PROD_W-1]};
    assign fits       = trial >= {1'b0, div_reg};
    assign trial_diff = trial - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= (state_reg == M_DIV) && (cnt_reg == CNT_W'(CKPD_PROD_W - 1));
            unique case (state_reg)
                M_IDLE: begin
                    if (start) begin
                        a_reg     <= op_a;
                        b_reg     <= {{(CKPD_PROD_W-CKPD_W){1'b0}}, op_b};
                        div_reg   <= divisor;
                        acc_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= M_MUL;
                    end
                end
                M_MUL: begin
                    acc_reg <= acc_sum;
                    a_reg   <= a_reg >> 1;
                    b_reg   <= b_reg << 1;
                    if (cnt_reg == CNT_W'(CKPD_W - 1)) begin
                        quot_reg  <= acc_sum;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= M_DIV;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                M_DIV: begin
                    rem_reg  <= fits ? trial_diff[CKPD_W-1:0] : trial[CKPD_W-1:0];
                    quot_reg <= {quot_reg[CKPD_PROD_W-2:0], fits};
                    if (cnt_reg == CNT_W'(CKPD_PROD_W - 1)) begin
                        state_reg <= M_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg[CKPD_W-1:0];

endmodule
`default_nettype wire

### src/ckpd_lane.sv
// One knob channel: offset curve then duty scaling on a serial multiply-divide unit.
`default_nettype none
module ckpd_lane (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [ckpd_pkg::CKPD_W-1:0] sample,
    input  wire logic [ckpd_pkg::CKPD_W-1:0] offset,
    input  wire logic                        ovr_en,
    input  wire logic [ckpd_pkg::CKPD_W-1:0] ovr_val,
    input  wire logic                        clamp_en,
    input  wire logic [ckpd_pkg::CKPD_W-1:0] mult,
    output logic                             done,
    output logic [ckpd_pkg::CKPD_HD_W-1:0]   duty
);
    import ckpd_pkg::*;

    typedef enum logic [1:0] {L_IDLE, L_CURVE, L_SCALE} lane_state_t;

    lane_state_t           state_reg;
    logic [CKPD_W-1:0]     off_reg;
    logic                  low_reg;
    logic                  done_reg;
    logic [CKPD_HD_W-1:0]  duty_reg;

    logic                  md_start;
    logic [CKPD_W-1:0]     md_a;
    logic [CKPD_W-1:0]     md_b;
    logic [CKPD_W-1:0]     md_d;
    logic                  md_done;
    logic [CKPD_W-1:0]     md_q;
    logic                  low_now;
    logic [CKPD_W:0]       map_sum;
    logic [CKPD_W-1:0]     map_val;
    logic [CKPD_W-1:0]     pick;
    logic [CKPD_W-1:0]     clamped;

    assign low_now = sample <= CKPD_CURVE_KNEE;
    assign map_sum = {1'b0, off_reg} + {1'b0, md_q};
    assign map_val = low_reg ? '0 : map_sum[CKPD_W-1:0];
    assign pick    = ovr_en ? ovr_val : map_val;

    always_comb begin
        clamped = pick;
        if (clamp_en) begin
            if (pick < CKPD_CLAMP_LOW) begin
                clamped = '0;
            end else if (pick > CKPD_CLAMP_HIGH) begin
                clamped = CKPD_FULL;
            end
        end
    end

    always_comb begin
        md_start = 1'b0;
        md_a     = clamped;
        md_b     = mult;
        md_d     = CKPD_SCALE_DIV;
        unique case (state_reg)
            L_IDLE: begin
                md_start = start;
                md_a     = low_now ? '0 : sample - CKPD_CURVE_KNEE;
                md_b     = CKPD_FULL - offset;
                md_d     = CKPD_CURVE_DIV;
            end
            L_CURVE: md_start = md_done;
            L_SCALE: md_start = 1'b0;
            default: md_start = 1'b0;
        endcase
    end

    ckpd_muldiv u_muldiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (md_start),
        .op_a     (md_a),
        .op_b     (md_b),
        .divisor  (md_d),
        .done     (md_done),
        .quotient (md_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= (state_reg == L_SCALE) && md_done;
            unique case (state_reg)
                L_IDLE: begin
                    if (start) begin
                        off_reg   <= offset;
                        low_reg   <= low_now;
                        state_reg <= L_CURVE;
                    end
                end
                L_CURVE: begin
                    if (md_done) begin
                        state_reg <= L_SCALE;
                    end
                end
                L_SCALE: begin
                    if (md_done) begin
                        duty_reg  <= md_q[CKPD_HD_W-1:0];
                        state_reg <= L_IDLE;
                    end
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign duty = duty_reg;

endmodule
`default_nettype wire

### src/ckpd_ctrl.sv
// Button timing, ramp generator, offset registers and saved calibration bytes.
`default_nettype none
module ckpd_ctrl (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              step,
    input  wire logic                              button,
    input  wire logic [ckpd_pkg::CKPD_W-1:0]       hard_sample,
    input  wire logic [ckpd_pkg::CKPD_W-1:0]       soft_sample,
    input  wire logic                              cfg_we,
    input  wire logic [ckpd_pkg::CKPD_IDX_W-1:0]   cfg_idx,
    input  wire logic [ckpd_pkg::CKPD_BYTE_W-1:0]  cfg_data,
    output ckpd_pkg::ckpd_ctrl_t                   ctrl,
    output logic [ckpd_pkg::CKPD_BYTE_W-1:0]       saved_hard_byte,
    output logic [ckpd_pkg::CKPD_BYTE_W-1:0]       saved_soft_byte
);
    import ckpd_pkg::*;

    logic                   last_reg,   last_next;
    logic [CKPD_W-1:0]      hold_reg,   hold_next;
    logic                   long_reg,   long_next;
    logic [CKPD_W-1:0]      ramp_reg,   ramp_next;
    logic [CKPD_W-1:0]      floor_reg,  floor_next;
    logic                   down_reg,   down_next;
    logic [CKPD_W-1:0]      hoff_reg,   hoff_next;
    logic [CKPD_W-1:0]      soff_reg,   soff_next;
    logic [CKPD_BYTE_W-1:0] shb_reg,    shb_next;
    logic [CKPD_BYTE_W-1:0] ssb_reg,    ssb_next;
    logic                   strobe_reg, strobe_next;
    logic [CKPD_BYTE_W-1:0] sh_reg,     sh_next;
    logic [CKPD_BYTE_W-1:0] sv_reg,     sv_next;

    always_comb begin
        last_next   = last_reg;
        hold_next   = hold_reg;
        long_next   = long_reg;
        ramp_next   = ramp_reg;
        floor_next  = floor_reg;
        down_next   = down_reg;
        hoff_next   = hoff_reg;
        soff_next   = soff_reg;
        shb_next    = shb_reg;
        ssb_next    = ssb_reg;
        strobe_next = strobe_reg;
        sh_next     = sh_reg;
        sv_next     = sv_reg;
        if (cfg_we) begin
            unique case (cfg_idx)
                CKPD_REG_HARD: begin
                    shb_next  = cfg_data;
                    hoff_next = ckpd_decode(cfg_data);
                end
                CKPD_REG_SOFT: begin
                    ssb_next  = cfg_data;
                    soff_next = ckpd_decode(cfg_data);
                end
                default: shb_next = shb_reg;
            endcase
        end
        if (step) begin
            strobe_next = 1'b0;
            sh_next     = '0;
            sv_next     = '0;
            if (last_reg && !button) begin
                hold_next  = '0;
                long_next  = 1'b0;
                ramp_next  = hoff_reg;
                floor_next = hoff_reg;
                down_next  = 1'b0;
            end
            if (!button) begin
                if (hold_next < CKPD_HOLD_MAX) begin
                    hold_next = hold_next + 1'b1;
                end
                if (hold_next > CKPD_HOLD_LONG) begin
                    long_next = 1'b1;
                end
                if (long_next) begin
                    if (!down_next) begin
                        if (ramp_next < CKPD_RAMP_TURN) begin
                            ramp_next = ramp_next + CKPD_RAMP_STEP;
                        end else begin
                            ramp_next = CKPD_FULL;
                            down_next = 1'b1;
                        end
                    end else begin
                        if ({1'b0, ramp_next} > {1'b0, floor_next} + CKPD_RAMP_MARGIN) begin
                            ramp_next = ramp_next - CKPD_RAMP_STEP;
                        end else begin
                            ramp_next = floor_next;
                            down_next = 1'b0;
                        end
                    end
                end
            end
            if (!last_reg && button) begin
                if (!long_next) begin
                    hoff_next   = hard_sample;
                    soff_next   = soft_sample;
                    sh_next     = hard_sample[CKPD_W-1:2];
                    sv_next     = soft_sample[CKPD_W-1:2];
                    shb_next    = hard_sample[CKPD_W-1:2];
                    ssb_next    = soft_sample[CKPD_W-1:2];
                    strobe_next = 1'b1;
                end
                hold_next = '0;
                long_next = 1'b0;
            end
            last_next = button;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg   <= 1'b1;
            hold_reg   <= '0;
            long_reg   <= 1'b0;
            ramp_reg   <= '0;
            floor_reg  <= '0;
            down_reg   <= 1'b0;
            hoff_reg   <= '0;
            soff_reg   <= '0;
            shb_reg    <= CKPD_NONE_STORED;
            ssb_reg    <= CKPD_NONE_STORED;
            strobe_reg <= 1'b0;
            sh_reg     <= '0;
            sv_reg     <= '0;
        end else begin
            last_reg   <= last_next;
            hold_reg   <= hold_next;
            long_reg   <= long_next;
            ramp_reg   <= ramp_next;
            floor_reg  <= floor_next;
            down_reg   <= down_next;
            hoff_reg   <= hoff_next;
            soff_reg   <= soff_next;
            shb_reg    <= shb_next;
            ssb_reg    <= ssb_next;
            strobe_reg <= strobe_next;
            sh_reg     <= sh_next;
            sv_reg     <= sv_next;
        end
    end

    assign ctrl.long_hold   = long_reg;
    assign ctrl.ramp_level  = ramp_reg;
    assign ctrl.hard_base   = hoff_reg;
    assign ctrl.soft_base   = soff_reg;
    assign ctrl.save_strobe = strobe_reg;
    assign ctrl.save_hard   = sh_reg;
    assign ctrl.save_soft   = sv_reg;
    assign saved_hard_byte  = shb_reg;
    assign saved_soft_byte  = ssb_reg;

endmodule
`default_nettype wire
